FILE: design/sjs_pkg.sv
// sjs_pkg: shared types and constants of the shortest-remaining-time scheduler
// used by sjs_ctrl, sjs_datapath and srpt_job_scheduler; no dependencies
package sjs_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int JOB_LEN_W = 16;
  localparam int TIME_W    = 32;
  localparam int SUM_W     = 40;
  localparam int PEND_W    = 7;

  // operation codes of an input transaction
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic begin_item;  // clear per-transaction result flags
    logic push;        // stamp new job, append at the tail
    logic up_rd;       // read parent of the hole
    logic up_move;     // move parent down into the hole
    logic tk_rd;       // read root and last entry
    logic tk_dec;      // write back root with one tick less
    logic tk_pop;      // root finished: report, take last entry
    logic time_inc;    // advance current time
    logic dn_rd;       // read both children of the hole
    logic dn_move;     // move smaller child up into the hole
    logic place;       // write carried entry into the hole
  } sjs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_arrival;
    logic arr_ok;
    logic cnt_zero;
    logic pos_zero;
    logic up_swap;
    logic rem_one;
    logic last_one;
    logic no_child;
    logic dn_swap;
  } sjs_status_t;

endpackage

FILE: design/sjs_ctrl.sv
// sjs_ctrl: one-hot state machine that sequences arrivals, ticks and heap sifts
// depends on sjs_pkg
module sjs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sjs_pkg::sjs_status_t status_i,
  output sjs_pkg::sjs_cmd_t   cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import sjs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UP_RD  = 7'b0000010,
    S_UP_CMP = 7'b0000100,
    S_TK_CHK = 7'b0001000,
    S_DN_RD  = 7'b0010000,
    S_DN_CMP = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE, S_DONE: begin
        state_d = S_IDLE;
        if (start_i) begin
          cmd_o.begin_item = 1'b1;
          if (status_i.is_arrival) begin
            if (status_i.arr_ok) begin
              cmd_o.push = 1'b1;
              state_d    = S_UP_RD;
            end else begin
              state_d = S_DONE;
            end
          end else if (status_i.cnt_zero) begin
            cmd_o.time_inc = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.tk_rd = 1'b1;
            state_d     = S_TK_CHK;
          end
        end
      end
      S_UP_RD: begin
        if (status_i.pos_zero) begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end else begin
          cmd_o.up_rd = 1'b1;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status_i.up_swap) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_TK_CHK: begin
        cmd_o.time_inc = 1'b1;
        if (status_i.rem_one) begin
          cmd_o.tk_pop = 1'b1;
          state_d      = status_i.last_one ? S_DONE : S_DN_RD;
        end else begin
          cmd_o.tk_dec = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DN_RD: begin
        if (status_i.no_child) begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end else begin
          cmd_o.dn_rd = 1'b1;
          state_d     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (status_i.dn_swap) begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // a new transaction may be taken in the cycle the result is shown
  assign busy_o = !(state_q == S_IDLE || state_q == S_DONE);
  assign done_o = (state_q == S_DONE);

endmodule

FILE: design/sjs_datapath.sv
// sjs_datapath: heap memory, job count, time, turnaround total and result registers
// depends on sjs_pkg; driven by sjs_ctrl commands
module sjs_datapath #(
  parameter int QUEUE_DEPTH = sjs_pkg::QUEUE_DEPTH_DEF,
  parameter int LENGTH_BITS = sjs_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          operation_i,
  input  logic [sjs_pkg::JOB_LEN_W-1:0] job_length_i,
  input  sjs_pkg::sjs_cmd_t             cmd_i,
  output sjs_pkg::sjs_status_t          status_o,
  output logic                          accepted_o,
  output logic                          finished_o,
  output logic [sjs_pkg::TIME_W-1:0]    turnaround_o,
  output logic [sjs_pkg::SUM_W-1:0]     total_wait_o,
  output logic [sjs_pkg::PEND_W-1:0]    pending_o
);
  import sjs_pkg::*;

  localparam int LEN_W = (LENGTH_BITS < JOB_LEN_W) ? LENGTH_BITS : JOB_LEN_W;
  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int IW    = CW + 1;

  typedef struct packed {
    logic [TIME_W-1:0] arr;
    logic [LEN_W-1:0]  rem;
  } entry_t;

  entry_t heap_mem [QUEUE_DEPTH];

  logic [CW-1:0]     cnt_q;
  logic [TIME_W-1:0] time_q;
  logic [SUM_W-1:0]  wait_q;
  logic [AW-1:0]     pos_q;
  entry_t            ent_q;
  entry_t            rd_a_q;
  entry_t            rd_b_q;
  logic              acc_q;
  logic              fin_q;
  logic [TIME_W-1:0] turn_q;

  logic [LEN_W-1:0]  len_in;
  logic [AW-1:0]     parent;
  logic [IW-1:0]     l_idx;
  logic [IW-1:0]     r_idx;
  logic              r_ok;
  logic              pick_l;
  entry_t            pick_ent;
  logic [AW-1:0]     pick_addr;
  logic [CW-1:0]     cnt_m1;
  logic [TIME_W-1:0] turn_new;
  logic [SUM_W:0]    sum_new;

  logic              we;
  logic [AW-1:0]     wa;
  entry_t            wd;
  logic              re_a;
  logic              re_b;
  logic [AW-1:0]     ra_a;
  logic [AW-1:0]     ra_b;

  assign len_in   = job_length_i[LEN_W-1:0];
  assign parent   = (pos_q - AW'(1)) >> 1;
  assign l_idx    = IW'({pos_q, 1'b1});
  assign r_idx    = l_idx + IW'(1);
  assign r_ok     = r_idx < IW'(cnt_q);
  // right child wins ties, left only when strictly smaller
  assign pick_l   = !r_ok || (rd_a_q.rem < rd_b_q.rem);
  assign pick_ent = pick_l ? rd_a_q : rd_b_q;
  assign pick_addr = pick_l ? l_idx[AW-1:0] : r_idx[AW-1:0];
  assign cnt_m1   = cnt_q - CW'(1);
  assign turn_new = time_q - rd_a_q.arr + TIME_W'(1);
  assign sum_new  = {1'b0, wait_q} + (SUM_W + 1)'(turn_new);

  always_comb begin
    status_o.is_arrival = (operation_i == OP_ARRIVE);
    status_o.arr_ok     = (len_in != '0) && (cnt_q < CW'(QUEUE_DEPTH));
    status_o.cnt_zero   = (cnt_q == '0);
    status_o.pos_zero   = (pos_q == '0);
    status_o.up_swap    = (rd_a_q.rem > ent_q.rem);
    status_o.rem_one    = (rd_a_q.rem == LEN_W'(1));
    status_o.last_one   = (cnt_q == CW'(1));
    status_o.no_child   = (l_idx >= IW'(cnt_q));
    status_o.dn_swap    = (pick_ent.rem < ent_q.rem);
  end

  // memory ports
  always_comb begin
    we   = cmd_i.place | cmd_i.up_move | cmd_i.dn_move | cmd_i.tk_dec;
    wa   = pos_q;
    wd   = ent_q;
    if (cmd_i.up_move) begin
      wd = rd_a_q;
    end else if (cmd_i.dn_move) begin
      wd = pick_ent;
    end else if (cmd_i.tk_dec) begin
      wa     = '0;
      wd.arr = rd_a_q.arr;
      wd.rem = rd_a_q.rem - LEN_W'(1);
    end
    re_a = cmd_i.up_rd | cmd_i.dn_rd | cmd_i.tk_rd;
    re_b = cmd_i.dn_rd | cmd_i.tk_rd;
    ra_a = cmd_i.up_rd ? parent : (cmd_i.dn_rd ? l_idx[AW-1:0] : '0);
    ra_b = cmd_i.tk_rd ? cnt_m1[AW-1:0] : r_idx[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[wa] <= wd;
    end
    if (re_a) begin
      rd_a_q <= heap_mem[ra_a];
    end
    if (re_b) begin
      rd_b_q <= heap_mem[ra_b];
    end
  end

  // carried entry, hole position and per-transaction results
  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_item) begin
      acc_q  <= cmd_i.push;
      fin_q  <= 1'b0;
      turn_q <= '0;
    end
    if (cmd_i.push) begin
      ent_q.arr <= time_q;
      ent_q.rem <= len_in;
      pos_q     <= cnt_q[AW-1:0];
    end
    if (cmd_i.up_move) begin
      pos_q <= parent;
    end
    if (cmd_i.dn_move) begin
      pos_q <= pick_addr;
    end
    if (cmd_i.tk_pop) begin
      fin_q  <= 1'b1;
      turn_q <= turn_new;
      ent_q  <= rd_b_q;
      pos_q  <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      time_q <= '0;
      wait_q <= '0;
    end else begin
      if (cmd_i.push) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.tk_pop) begin
        cnt_q <= cnt_m1;
      end
      if (cmd_i.time_inc) begin
        time_q <= time_q + TIME_W'(1);
      end
      if (cmd_i.tk_pop) begin
        // saturate the total on carry out
        wait_q <= sum_new[SUM_W] ? {SUM_W{1'b1}} : sum_new[SUM_W-1:0];
      end
    end
  end

  assign accepted_o   = acc_q;
  assign finished_o   = fin_q;
  assign turnaround_o = turn_q;
  assign total_wait_o = wait_q;
  assign pending_o    = PEND_W'(cnt_q);

endmodule

FILE: design/srpt_job_scheduler.sv
// srpt_job_scheduler: preemptive shortest-remaining-time scheduler on a min-heap
// steps: a refused arrival or a tick on an empty queue goes from S_IDLE straight to S_DONE;
// a tick that does not finish a job passes S_TK_CHK first; a sift repeats its read and compare
// states per heap level. Throughput: one transaction per result; the next start is taken in the
// strobe cycle; the sift loop does one heap memory read and one compare per level
// reset: async active low clears count, time and total; heap contents need no clearing
module srpt_job_scheduler #(
  parameter int QUEUE_DEPTH = sjs_pkg::QUEUE_DEPTH_DEF,
  parameter int LENGTH_BITS = sjs_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [sjs_pkg::JOB_LEN_W-1:0] job_length_i,
  output logic                          done_o,
  output logic                          accepted_o,
  output logic                          finished_o,
  output logic [sjs_pkg::TIME_W-1:0]    turnaround_o,
  output logic [sjs_pkg::SUM_W-1:0]     total_wait_o,
  output logic [sjs_pkg::PEND_W-1:0]    pending_o
);
  import sjs_pkg::*;

  sjs_cmd_t    cmd;
  sjs_status_t status;

  sjs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  sjs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .operation_i  (operation_i),
    .job_length_i (job_length_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .accepted_o   (accepted_o),
    .finished_o   (finished_o),
    .turnaround_o (turnaround_o),
    .total_wait_o (total_wait_o),
    .pending_o    (pending_o)
  );

endmodule
